@@ hdl/cursor_linked_list_engine_top_defines.svh @@
// Assertion macros for the cursor linked list engine.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef CURSOR_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLL_ASSERT(label, clk, rst, prop, msg)
`define CLL_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ hdl/cll_pkg.sv @@
// Shared constants, codes and beat types of the cursor linked list engine.
// No dependencies.
package cll_pkg;

   localparam int SLOTS     = 1024;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int HEAD_SLOT = SLOTS - 1;
   localparam int POS_W     = 10;
   localparam int VAL_W     = 32;
   localparam int LEN_W     = 10;
   localparam int CMP_W     = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                   command;
      logic [POS_W-1:0]          position;
      logic signed [VAL_W-1:0]   new_value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VAL_W-1:0]   removed_value;
      logic [LEN_W-1:0]          list_length;
   } rsp_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_GOT_FREE,
      S_GOT_FNXT,
      S_WALK,
      S_LINK,
      S_DEL_GOT,
      S_DEL_FREE,
      S_DEL_PUSH
   } state_type;

endpackage

@@ hdl/cll_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/cursor_linked_list_engine_top.sv @@
// Out-of-range commands are answered from idle; an insert into a full store once
// the free-chain head is read; inserts and deletes after the cursor walk.
// Throughput: one command at a time; the cursor walk does one memory read per
// position step.
// Reset: synchronous; afterwards a sweep over all SLOTS slots builds the free
// chain in the cursor memory, during which req_stall is high.
// Depends on cll_pkg, cll_ram and cursor_linked_list_engine_top_defines.svh.
`include "cursor_linked_list_engine_top_defines.svh"
module cursor_linked_list_engine_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cll_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cll_pkg::rsp_type rsp_data
);
   import cll_pkg::*;

   state_type               state_ff, state_in;
   logic [SLOT_W-1:0]       init_ff, init_in;
   logic [SLOT_W-1:0]       k_ff, k_in;
   logic [SLOT_W-1:0]       pred_ff, pred_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [POS_W-1:0]        remain_ff, remain_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [VAL_W-1:0]        val_ff, val_in;
   logic [SLOT_W-1:0]       count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    nx_we;
   logic [SLOT_W-1:0]       nx_waddr, nx_wdata, nx_raddr, nx_rdata;
   logic                    val_we;
   logic [VAL_W-1:0]        val_rdata;

   logic                    req_fire;
   logic                    res_fire;
   status_type              res_status;
   logic [VAL_W-1:0]        res_removed;
   logic [CMP_W-1:0]        pos_x, cnt_x;
   logic                    range_bad;

   cll_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next_ram (
      .clock (clock),
      .we    (nx_we),
      .waddr (nx_waddr),
      .wdata (nx_wdata),
      .raddr (nx_raddr),
      .rdata (nx_rdata)
   );

   cll_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (slot_ff),
      .wdata (val_ff),
      .raddr (nx_raddr),
      .rdata (val_rdata)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;
   assign pos_x     = CMP_W'(req_data.position);
   assign cnt_x     = CMP_W'(count_ff);

   always_comb begin
      if (req_data.command == CMD_INSERT) begin
         range_bad = (pos_x == '0) || (pos_x > cnt_x + CMP_W'(1));
      end else begin
         range_bad = (pos_x == '0) || (pos_x > cnt_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      pred_ff   <= pred_in;
      slot_ff   <= slot_in;
      remain_ff <= remain_in;
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in    = state_ff;
      init_in     = init_ff;
      k_in        = k_ff;
      pred_in     = pred_ff;
      slot_in     = slot_ff;
      remain_in   = remain_ff;
      cmd_in      = cmd_ff;
      val_in      = val_ff;
      count_in    = count_ff;
      nx_we       = 1'b0;
      nx_waddr    = '0;
      nx_wdata    = '0;
      nx_raddr    = '0;
      val_we      = 1'b0;
      res_fire    = 1'b0;
      res_status  = ST_OK;
      res_removed = '0;

      unique case (state_ff)
         S_INIT: begin
            nx_we    = 1'b1;
            nx_waddr = init_ff;
            nx_wdata = (init_ff <= SLOT_W'(SLOTS - 3)) ? init_ff + SLOT_W'(1) : '0;
            init_in  = init_ff + SLOT_W'(1);
            if (init_ff == SLOT_W'(HEAD_SLOT)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_data.command;
               val_in    = req_data.new_value;
               remain_in = req_data.position - POS_W'(1);
               k_in      = SLOT_W'(HEAD_SLOT);
               if (range_bad) begin
                  res_fire   = 1'b1;
                  res_status = ST_RANGE;
               end else if (req_data.command == CMD_INSERT) begin
                  nx_raddr = '0;
                  state_in = S_GOT_FREE;
               end else begin
                  nx_raddr = SLOT_W'(HEAD_SLOT);
                  state_in = S_WALK;
               end
            end
         end
         S_GOT_FREE: begin
            if (nx_rdata == '0) begin
               res_fire   = 1'b1;
               res_status = ST_FULL;
               state_in   = S_IDLE;
            end else begin
               slot_in  = nx_rdata;
               nx_raddr = nx_rdata;
               state_in = S_GOT_FNXT;
            end
         end
         S_GOT_FNXT: begin
            // pop the free head, store the value, start the walk at the list head
            nx_we    = 1'b1;
            nx_waddr = '0;
            nx_wdata = nx_rdata;
            val_we   = 1'b1;
            nx_raddr = SLOT_W'(HEAD_SLOT);
            state_in = S_WALK;
         end
         S_WALK: begin
            if (remain_ff != '0) begin
               k_in      = nx_rdata;
               nx_raddr  = nx_rdata;
               remain_in = remain_ff - POS_W'(1);
            end else begin
               pred_in = k_ff;
               if (cmd_ff == CMD_INSERT) begin
                  nx_we    = 1'b1;
                  nx_waddr = slot_ff;
                  nx_wdata = nx_rdata;
                  state_in = S_LINK;
               end else begin
                  slot_in  = nx_rdata;
                  nx_raddr = nx_rdata;
                  state_in = S_DEL_GOT;
               end
            end
         end
         S_LINK: begin
            nx_we      = 1'b1;
            nx_waddr   = pred_ff;
            nx_wdata   = slot_ff;
            count_in   = count_ff + SLOT_W'(1);
            res_fire   = 1'b1;
            res_status = ST_OK;
            state_in   = S_IDLE;
         end
         S_DEL_GOT: begin
            // unlink: predecessor takes the removed slot's successor
            nx_we    = 1'b1;
            nx_waddr = pred_ff;
            nx_wdata = nx_rdata;
            val_in   = val_rdata;
            nx_raddr = '0;
            state_in = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            nx_we    = 1'b1;
            nx_waddr = slot_ff;
            nx_wdata = nx_rdata;
            state_in = S_DEL_PUSH;
         end
         S_DEL_PUSH: begin
            nx_we       = 1'b1;
            nx_waddr    = '0;
            nx_wdata    = slot_ff;
            count_in    = count_ff - SLOT_W'(1);
            res_fire    = 1'b1;
            res_status  = ST_OK;
            res_removed = val_ff;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (res_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = res_status;
         rsp_in.removed_value = res_removed;
         rsp_in.list_length   = LEN_W'(count_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CLL_ASSERT(a_count_bound, clock, reset, count_ff <= SLOT_W'(SLOTS - 2), "list count above capacity")
   `CLL_ASSERT(a_init_stalls, clock, reset, (state_ff == S_INIT) |-> req_stall, "beat taken during init sweep")
   `CLL_ASSERT(a_res_slot_free, clock, reset, res_fire |-> !(rsp_valid_ff && rsp_stall), "result overwrites a held beat")
   `CLL_ASSERT(a_count_on_result, clock, reset, !$stable(count_ff) |-> $past(res_fire), "count changed without a result")

endmodule

@@ test/testbench.sv @@
// Self-checking bench for cursor_linked_list_engine_top: insert and delete traffic checked
// against a slot-array list predictor, with random sender gaps and receiver stalls.
// Depends on cll_pkg and the engine RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cll_pkg::*;

   localparam int CYCLE_LIMIT  = 6_000_000;
   localparam int RANDOM_COUNT = 320;
   localparam int GROW_COUNT   = 180;
   localparam int HOLD_CYCLES  = 400;
   localparam int CAPACITY     = SLOTS - 2;
   localparam int TAIL_CYCLES  = SLOTS + 64;

   typedef enum {RX_FLOWING, RX_SPARSE, RX_HEAVY} rx_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   cursor_linked_list_engine_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // list predictor state
   logic [SLOT_W-1:0]       link_mem  [SLOTS];
   logic signed [VAL_W-1:0] value_mem [SLOTS];
   int unsigned             list_count;
   rsp_type                 pending_rsp [$];

   int      cycle_count    = 0;
   int      sent_count     = 0;
   int      checked_count  = 0;
   int      mismatch_count = 0;
   int      range_seen     = 0;
   int      full_seen      = 0;
   int      peak_len       = 0;
   int      burst_left     = 0;
   bit      steady         = 1'b0;
   int      hold_ticket    = 0;
   rsp_type due_rsp;

   function automatic void list_clear();
      for (int i = 0; i < SLOTS; i++) begin
         link_mem[i]  = '0;
         value_mem[i] = '0;
      end
      for (int i = 0; i + 2 < SLOTS; i++) link_mem[i] = SLOT_W'(i + 1);
      link_mem[SLOTS-2]   = '0;
      link_mem[HEAD_SLOT] = '0;
      list_count = 0;
   endfunction

   function automatic int unsigned walk_predecessor(int unsigned pos);
      int unsigned k;
      k = HEAD_SLOT;
      for (int unsigned n = 1; n < pos; n++) k = link_mem[k];
      return k;
   endfunction

   function automatic rsp_type list_apply(req_type cmd);
      rsp_type     r;
      int unsigned pos;
      int unsigned slot;
      int unsigned k;
      r        = '0;
      r.status = ST_OK;
      pos      = cmd.position;
      if (cmd.command == CMD_INSERT) begin
         if (pos < 1 || pos > list_count + 1) begin
            r.status = ST_RANGE;
         end else if (link_mem[0] == '0) begin
            r.status = ST_FULL;
         end else begin
            slot             = link_mem[0];
            link_mem[0]      = link_mem[slot];
            value_mem[slot]  = cmd.new_value;
            k                = walk_predecessor(pos);
            link_mem[slot]   = link_mem[k];
            link_mem[k]      = SLOT_W'(slot);
            list_count++;
         end
      end else begin
         if (pos < 1 || pos > list_count) begin
            r.status = ST_RANGE;
         end else begin
            k               = walk_predecessor(pos);
            slot            = link_mem[k];
            r.removed_value = value_mem[slot];
            link_mem[k]     = link_mem[slot];
            link_mem[slot]  = link_mem[0];
            link_mem[0]     = SLOT_W'(slot);
            list_count--;
         end
      end
      r.list_length = LEN_W'(list_count);
      return r;
   endfunction

   task automatic send_cmd(input cmd_type op, input int unsigned pos,
                           input logic signed [VAL_W-1:0] val);
      req_type item;
      rsp_type exp_rsp;
      int      gap;
      item.command   = op;
      item.position  = POS_W'(pos);
      item.new_value = val;
      if (!steady && burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      exp_rsp = list_apply(item);
      pending_rsp.push_back(exp_rsp);
      sent_count++;
      if (exp_rsp.status == ST_RANGE) range_seen++;
      if (exp_rsp.status == ST_FULL) full_seen++;
      if (list_count > peak_len) peak_len = list_count;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: status %0d removed %0d length %0d",
                        rsp_data.status, rsp_data.removed_value, rsp_data.list_length);
         end else begin
            due_rsp = pending_rsp.pop_front();
            checked_count++;
            if (rsp_data.status !== due_rsp.status ||
                rsp_data.removed_value !== due_rsp.removed_value ||
                rsp_data.list_length !== due_rsp.list_length) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           checked_count, due_rsp.status, due_rsp.removed_value,
                           due_rsp.list_length, rsp_data.status, rsp_data.removed_value,
                           rsp_data.list_length);
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off during the backpressure test
   rx_mode_type rx_mode   = RX_FLOWING;
   int          mode_left = 0;
   int          hold_left = 0;
   int          hold_seen = 0;

   always @(posedge clock) begin
      if (hold_seen != hold_ticket) begin
         hold_seen = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(10, 200);
         end
         mode_left--;
         case (rx_mode)
            RX_FLOWING: rsp_stall <= 1'b0;
            RX_SPARSE:  rsp_stall <= ($urandom_range(0, 3) == 0);
            default:    rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cursor_linked_list_engine_top: mismatch");
      $finish;
   end

   task automatic test_directed();
      send_cmd(CMD_DELETE, 1, $urandom);
      send_cmd(CMD_DELETE, 0, $urandom);
      send_cmd(CMD_INSERT, 0, 5);
      send_cmd(CMD_INSERT, 2, 7);
      send_cmd(CMD_INSERT, 1, 32'sh7fffffff);
      send_cmd(CMD_INSERT, 2, 32'sh80000000);
      send_cmd(CMD_INSERT, 1, '1);
      send_cmd(CMD_INSERT, 2, '0);
      send_cmd(CMD_INSERT, 1023, 1);
      send_cmd(CMD_DELETE, 1023, $urandom);
      send_cmd(CMD_DELETE, 5, $urandom);
      send_cmd(CMD_INSERT, 5, $urandom);
      send_cmd(CMD_INSERT, 7, $urandom);
      send_cmd(CMD_DELETE, 3, 32'sh5a5a5a5a);
      send_cmd(CMD_DELETE, 4, $urandom);
      send_cmd(CMD_DELETE, 1, $urandom);
      send_cmd(CMD_DELETE, 1, $urandom);
      send_cmd(CMD_DELETE, 1, $urandom);
      send_cmd(CMD_DELETE, 1, $urandom);
      send_cmd(CMD_INSERT, 1, $urandom);
   endtask

   task automatic test_random_traffic();
      cmd_type     op;
      int unsigned pos;
      int          ins_pct;
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if ($urandom_range(0, 99) < 12) begin
            op = $urandom_range(0, 1) ? CMD_DELETE : CMD_INSERT;
            case ($urandom_range(0, 2))
               0:       pos = 0;
               1:       pos = (op == CMD_INSERT) ? list_count + 2 : list_count + 1;
               default: pos = $urandom_range(0, 1023);
            endcase
         end else begin
            ins_pct = (list_count < 4) ? 75 : (list_count > 40) ? 25 : 50;
            if (list_count == 0 || $urandom_range(0, 99) < ins_pct) begin
               op  = CMD_INSERT;
               pos = $urandom_range(1, list_count + 1);
            end else begin
               op  = CMD_DELETE;
               pos = $urandom_range(1, list_count);
            end
         end
         send_cmd(op, pos, pick_value());
      end
   endtask

   task automatic test_backpressure();
      steady = 1'b1;
      hold_ticket++;
      for (int i = 0; i < 12; i++) begin
         if ($urandom_range(0, 2) == 0) send_cmd(CMD_DELETE, 0, $urandom);
         else send_cmd(CMD_INSERT, 1, pick_value());
      end
      steady = 1'b0;
      wait_results();
   endtask

   task automatic test_deep_list();
      cmd_type     op;
      int unsigned target;
      target = list_count + GROW_COUNT;
      while (list_count < target)
         send_cmd(CMD_INSERT, $urandom_range(1, list_count + 1), pick_value());
      send_cmd(CMD_INSERT, 1023, $urandom);
      send_cmd(CMD_INSERT, 0, $urandom);
      send_cmd(CMD_DELETE, 1023, $urandom);
      send_cmd(CMD_DELETE, 0, $urandom);
      send_cmd(CMD_DELETE, list_count, $urandom);
      send_cmd(CMD_INSERT, list_count + 1, pick_value());
      send_cmd(CMD_INSERT, list_count + 2, $urandom);
      send_cmd(CMD_DELETE, list_count + 1, $urandom);
      for (int i = 0; i < 10; i++) begin
         op = $urandom_range(0, 1) ? CMD_DELETE : CMD_INSERT;
         send_cmd(op, $urandom_range(0, 1023), pick_value());
      end
   endtask

   initial begin
      list_clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_results();
      test_random_traffic();
      wait_results();
      test_backpressure();
      test_deep_list();
      wait_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d commands, checked %0d results: %0d out of range, %0d store full",
               sent_count, checked_count, range_seen, full_seen);
      $display("peak list length %0d of %0d, with one %0d-cycle receiver hold-off",
               peak_len, CAPACITY, HOLD_CYCLES);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("cursor_linked_list_engine_top: match");
      end else begin
         $display("cursor_linked_list_engine_top: mismatch");
      end
      $finish;
   end

endmodule

@@ cursor_linked_list_engine_top.f @@
+incdir+hdl
hdl/cll_pkg.sv
hdl/cll_ram.sv
hdl/cursor_linked_list_engine_top.sv
test/testbench.sv
